@@ design/urse_pkg.sv @@
// ----------------------------------------------------------------------------
// urse_pkg: shared types and constants
// Status codes, register indexes, configuration and queue entry types for the
// response signal extractor.
// ----------------------------------------------------------------------------
package urse_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 4;
    localparam int unsigned ACC_W           = 8 * MAX_FIELD_BYTES;
    localparam int unsigned SUM_W           = ACC_W + 2;
    localparam int unsigned SCALE_W         = 24;
    localparam int unsigned OFFSET_W        = 16;
    localparam int unsigned VALUE_W         = 57;
    localparam int unsigned PROD_W          = SUM_W + SCALE_W;
    localparam int unsigned CFG_DATA_W      = 24;

    localparam logic [7:0] RDBI_POS_RESP  = 8'h62;
    localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_SHORT    = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_SIGNAL_ENABLE = 3'd0,
        REG_EXPECTED_ID   = 3'd1,
        REG_FIELD_START   = 3'd2,
        REG_FIELD_BYTES   = 3'd3,
        REG_FIELD_SIGNED  = 3'd4,
        REG_MSB_FIRST     = 3'd5,
        REG_RAW_OFFSET    = 3'd6,
        REG_SCALE_FACTOR  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                       signal_enable;
        logic [15:0]                expected_identifier;
        logic [7:0]                 field_start;
        logic [2:0]                 field_bytes;
        logic                       field_signed;
        logic                       msb_first;
        logic signed [OFFSET_W-1:0] raw_offset;
        logic signed [SCALE_W-1:0]  scale_factor;
    } cfg_t;

    typedef struct packed {
        status_t                 status;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ design/urse_front.sv @@
// ----------------------------------------------------------------------------
// urse_front: byte intake and classification
// Tracks position, service byte, identifier and raw field bytes of the
// response; on the last byte it works out the status and offset raw value.
// ----------------------------------------------------------------------------
module urse_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  urse_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 push,
    output urse_pkg::entry_t     push_entry
);

    logic [7:0]                  cnt_reg, cnt_next;
    logic [7:0]                  svc_reg, svc_next;
    logic [15:0]                 id_reg, id_next;
    logic [urse_pkg::ACC_W-1:0]  acc_reg, acc_next;

    logic                        accept;
    logic [2:0]                  len;
    logic [8:0]                  field_end;
    logic [1:0]                  k;
    logic                        in_field;
    logic [7:0]                  n;
    logic [urse_pkg::ACC_W-1:0]  acc_upd;
    logic [7:0]                  svc_upd;
    logic [15:0]                 id_upd;
    logic signed [urse_pkg::SUM_W-1:0] raw;
    urse_pkg::status_t           status;

    assign accept    = in_valid && in_ready;
    assign len       = (cfg.field_bytes > 3'(urse_pkg::MAX_FIELD_BYTES))
                       ? 3'(urse_pkg::MAX_FIELD_BYTES) : cfg.field_bytes;
    assign field_end = {1'b0, cfg.field_start} + {6'b0, len};
    assign k         = 2'(cnt_reg - cfg.field_start);
    assign in_field  = (cnt_reg != urse_pkg::BYTE_COUNT_MAX)
                       && (cnt_reg >= cfg.field_start)
                       && ({1'b0, cnt_reg} < field_end);
    assign n         = (cnt_reg == urse_pkg::BYTE_COUNT_MAX) ? cnt_reg : cnt_reg + 8'd1;

    always_comb begin
        svc_upd = (cnt_reg == 8'd0) ? in_byte : svc_reg;
        id_upd  = id_reg;
        if (cnt_reg == 8'd1) begin
            id_upd[15:8] = in_byte;
        end
        if (cnt_reg == 8'd2) begin
            id_upd[7:0] = in_byte;
        end
        acc_upd = acc_reg;
        if (in_field) begin
            if (cfg.msb_first) begin
                acc_upd = {acc_reg[urse_pkg::ACC_W-9:0], in_byte};
            end else begin
                acc_upd = acc_reg | (urse_pkg::ACC_W'(in_byte) << {k, 3'b000});
            end
        end
    end

    // raw field, optionally sign-extended from its byte width
    always_comb begin
        case (len)
            3'd0: raw = '0;
            3'd1: raw = cfg.field_signed
                        ? {{(urse_pkg::SUM_W-8){acc_upd[7]}}, acc_upd[7:0]}
                        : {2'b00, acc_upd};
            3'd2: raw = cfg.field_signed
                        ? {{(urse_pkg::SUM_W-16){acc_upd[15]}}, acc_upd[15:0]}
                        : {2'b00, acc_upd};
            3'd3: raw = cfg.field_signed
                        ? {{(urse_pkg::SUM_W-24){acc_upd[23]}}, acc_upd[23:0]}
                        : {2'b00, acc_upd};
            default: raw = cfg.field_signed
                        ? {{(urse_pkg::SUM_W-32){acc_upd[31]}}, acc_upd[31:0]}
                        : {2'b00, acc_upd};
        endcase
    end

    always_comb begin
        if (!cfg.signal_enable) begin
            status = urse_pkg::ST_DISABLED;
        end else if ({1'b0, n} < field_end) begin
            status = urse_pkg::ST_SHORT;
        end else if ((n >= 8'd3) && ((svc_upd != urse_pkg::RDBI_POS_RESP)
                     || (id_upd != cfg.expected_identifier))) begin
            status = urse_pkg::ST_MISMATCH;
        end else begin
            status = urse_pkg::ST_OK;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        svc_next = svc_reg;
        id_next  = id_reg;
        acc_next = acc_reg;
        if (accept) begin
            if (in_last) begin
                cnt_next = '0;
                svc_next = '0;
                id_next  = '0;
                acc_next = '0;
            end else begin
                cnt_next = n;
                svc_next = svc_upd;
                id_next  = id_upd;
                acc_next = acc_upd;
            end
        end
    end

    assign push              = accept && in_last;
    assign push_entry.status = status;
    assign push_entry.sum    = raw + urse_pkg::SUM_W'(cfg.raw_offset);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            svc_reg <= '0;
            id_reg  <= '0;
            acc_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            svc_reg <= svc_next;
            id_reg  <= id_next;
            acc_reg <= acc_next;
        end
    end

endmodule

@@ design/urse_queue.sv @@
// ----------------------------------------------------------------------------
// urse_queue: classified response queue
// Small first-in first-out buffer between intake and the scaling stage.
// ----------------------------------------------------------------------------
module urse_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  urse_pkg::entry_t       push_entry,
    input  logic                   pop,
    output urse_pkg::entry_t       head,
    output urse_pkg::queue_stat_t  stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    urse_pkg::entry_t  mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next;
    logic [AW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/urse_back.sv @@
// ----------------------------------------------------------------------------
// urse_back: scaling and result register
// Multiplies the offset raw value by the resolution, zero unless status is ok,
// and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module urse_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [urse_pkg::SCALE_W-1:0]   scale_factor,
    input  urse_pkg::entry_t                      head,
    input  logic                                  head_valid,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output urse_pkg::status_t                     out_status,
    output logic [urse_pkg::VALUE_W-1:0]          out_value
);

    logic                                 valid_reg, valid_next;
    urse_pkg::status_t                    status_reg;
    logic [urse_pkg::VALUE_W-1:0]         value_reg;
    logic signed [urse_pkg::PROD_W-1:0]   product;

    assign pop     = head_valid && (!valid_reg || out_ready);
    assign product = urse_pkg::PROD_W'(head.sum) * urse_pkg::PROD_W'(scale_factor);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= head.status;
            value_reg  <= (head.status == urse_pkg::ST_OK)
                          ? product[urse_pkg::VALUE_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_value  = value_reg;

endmodule

@@ design/uds_response_signal_extractor_core.sv @@
// ----------------------------------------------------------------------------
// uds_response_signal_extractor_core: response signal extractor, top level
// Takes one response byte per transfer and gives one status and scaled value
// per response, on its last byte.
// Path: a last byte's entry goes through the queue, then the result register.
// Throughput: one byte per cycle while the queue has room; one result per
// cycle while m_tready is high. Reset: synchronous active-low aresetn clears
// byte tracking, queue and result valid, and loads the register reset values.
// ----------------------------------------------------------------------------
module uds_response_signal_extractor_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // resp_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [63:0]                          m_tdata,   // value, zero padded
    output logic [1:0]                           m_tuser,   // status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [urse_pkg::CFG_DATA_W-1:0]      cfg_data
);

    urse_pkg::cfg_t         cfg_reg, cfg_next;
    logic                   push;
    urse_pkg::entry_t       push_entry;
    logic                   pop;
    urse_pkg::entry_t       head;
    urse_pkg::queue_stat_t  q_stat;
    urse_pkg::status_t      out_status;
    logic [urse_pkg::VALUE_W-1:0] out_value;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (urse_pkg::cfg_index_t'(cfg_index))
                urse_pkg::REG_SIGNAL_ENABLE: cfg_next.signal_enable = cfg_data[0];
                urse_pkg::REG_EXPECTED_ID:   cfg_next.expected_identifier = cfg_data[15:0];
                urse_pkg::REG_FIELD_START:   cfg_next.field_start = cfg_data[7:0];
                urse_pkg::REG_FIELD_BYTES:   cfg_next.field_bytes = cfg_data[2:0];
                urse_pkg::REG_FIELD_SIGNED:  cfg_next.field_signed = cfg_data[0];
                urse_pkg::REG_MSB_FIRST:     cfg_next.msb_first = cfg_data[0];
                urse_pkg::REG_RAW_OFFSET:
                    cfg_next.raw_offset = cfg_data[urse_pkg::OFFSET_W-1:0];
                urse_pkg::REG_SCALE_FACTOR:
                    cfg_next.scale_factor = cfg_data[urse_pkg::SCALE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.signal_enable       <= 1'b0;
            cfg_reg.expected_identifier <= '0;
            cfg_reg.field_start         <= '0;
            cfg_reg.field_bytes         <= 3'd1;
            cfg_reg.field_signed        <= 1'b0;
            cfg_reg.msb_first           <= 1'b1;
            cfg_reg.raw_offset          <= '0;
            cfg_reg.scale_factor        <= 24'sh010000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !q_stat.full;

    urse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    urse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    urse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scale_factor (cfg_reg.scale_factor),
        .head         (head),
        .head_valid   (!q_stat.empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_value    (out_value)
    );

    assign m_tuser = out_status;
    assign m_tdata = {{(64 - urse_pkg::VALUE_W){1'b0}}, out_value};

    // value is zero for every status other than ok
    a_value_zero_unless_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != urse_pkg::ST_OK)) |-> (m_tdata == '0))
        else $error("nonzero value with failing status");

    // a new result only comes out of a queue that held an entry
    a_result_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!q_stat.empty))
        else $error("result appeared without a queued response");

    // queue is only written when it has room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.full && !pop) |=> (q_stat.full || $past(pop)) || !$past(push))
        else $error("queue written while full");

endmodule
